FILE: sv/websocket_text_frame_encoder_assert.svh
// Assertion macros for the WebSocket text frame encoder checker.
// Needs a signal named clock and a signal named reset in the scope of use.
`ifndef WEBSOCKET_TEXT_FRAME_ENCODER_ASSERT_SVH
`define WEBSOCKET_TEXT_FRAME_ENCODER_ASSERT_SVH

// Same-cycle implication, idle during reset.
`define WTFE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wtfe: same-cycle check failed");

// Next-cycle implication, idle during reset.
`define WTFE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wtfe: next-cycle check failed");

`endif

FILE: sv/wtfe_pkg.sv
// Shared types, constants and header byte functions of the frame encoder.
// No dependencies; used by every module of the block.
`default_nettype none
package wtfe_pkg;

   localparam logic [7:0] HDR_FIRST  = 8'h81;
   localparam logic [7:0] MASK_FLAG  = 8'h80;
   localparam logic [31:0] LEN7_MAX  = 32'd125;
   localparam logic [31:0] LEN16_MAX = 32'h0000_FFFF;
   localparam logic [6:0] LEN16_CODE = 7'd126;
   localparam logic [6:0] LEN64_CODE = 7'd127;

   // Position of the first key byte within each header form.
   localparam logic [3:0] KEY_POS_SHORT = 4'd2;
   localparam logic [3:0] KEY_POS_MED   = 4'd4;
   localparam logic [3:0] KEY_POS_LONG  = 4'd10;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   localparam logic REQ_START   = 1'b0;
   localparam logic REQ_PAYLOAD = 1'b1;

   typedef enum logic [2:0] {
      CMD_HDR_SHORT,
      CMD_HDR_MED,
      CMD_HDR_LONG,
      CMD_DATA,
      CMD_ERR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [31:0]  len;
      logic [31:0]  key;
      logic [7:0]   data;
      logic         frame_end;
   } cmd_type;

   function automatic logic [7:0] key_byte(logic [31:0] key, logic [1:0] phase);
      logic [7:0] b;
      case (phase)
         2'd0:    b = key[31:24];
         2'd1:    b = key[23:16];
         2'd2:    b = key[15:8];
         default: b = key[7:0];
      endcase
      return b;
   endfunction

   function automatic logic [3:0] key_pos(cmd_kind_type kind);
      logic [3:0] p;
      unique case (kind)
         CMD_HDR_MED:  p = KEY_POS_MED;
         CMD_HDR_LONG: p = KEY_POS_LONG;
         default:      p = KEY_POS_SHORT;
      endcase
      return p;
   endfunction

   function automatic logic [7:0] hdr_byte(cmd_kind_type kind, logic [31:0] len,
                                           logic [31:0] key, logic [3:0] idx);
      logic [3:0] kbase;
      logic [3:0] kofs;
      logic [7:0] b;
      kbase = key_pos(kind);
      kofs  = idx - kbase;
      b     = key_byte(key, kofs[1:0]);
      if (idx == 4'd0) begin
         b = HDR_FIRST;
      end else if (idx == 4'd1) begin
         unique case (kind)
            CMD_HDR_MED:  b = MASK_FLAG | {1'b0, LEN16_CODE};
            CMD_HDR_LONG: b = MASK_FLAG | {1'b0, LEN64_CODE};
            default:      b = MASK_FLAG | {1'b0, len[6:0]};
         endcase
      end else if (idx < kbase) begin
         case (idx)
            4'd2:    b = (kind == CMD_HDR_MED) ? len[15:8] : 8'h00;
            4'd3:    b = (kind == CMD_HDR_MED) ? len[7:0]  : 8'h00;
            4'd6:    b = len[31:24];
            4'd7:    b = len[23:16];
            4'd8:    b = len[15:8];
            4'd9:    b = len[7:0];
            default: b = 8'h00;
         endcase
      end
      return b;
   endfunction

endpackage
`default_nettype wire

FILE: sv/wtfe_front.sv
// Front end: accepts items, keeps key, phase and length state, masks payload.
// Depends on wtfe_pkg; feeds commands to wtfe_cmd_fifo.
`default_nettype none
module wtfe_front import wtfe_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic        req_type,
   input  wire logic [31:0] req_payload_len,
   input  wire logic [31:0] req_mask_key,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        fifo_full,
   output logic             cmd_push,
   output cmd_type          cmd
);

   logic [31:0] key_ff, key_in;
   logic [1:0]  phase_ff, phase_in;
   logic [31:0] left_ff, left_in;
   logic        accept;

   assign full     = fifo_full;
   assign accept   = push && !fifo_full;
   assign cmd_push = accept;

   always_comb begin
      key_in   = key_ff;
      phase_in = phase_ff;
      left_in  = left_ff;
      cmd      = '{kind: CMD_ERR, len: req_payload_len, key: req_mask_key,
                   data: 8'h00, frame_end: 1'b0};
      if (req_type == REQ_START) begin
         key_in   = req_mask_key;
         phase_in = 2'd0;
         left_in  = req_payload_len;
         if (req_payload_len <= LEN7_MAX) begin
            cmd.kind = CMD_HDR_SHORT;
         end else if (req_payload_len <= LEN16_MAX) begin
            cmd.kind = CMD_HDR_MED;
         end else begin
            cmd.kind = CMD_HDR_LONG;
         end
      end else if (left_ff != 32'd0) begin
         // consume one byte of the frame
         cmd.kind      = CMD_DATA;
         cmd.data      = req_data_byte ^ key_byte(key_ff, phase_ff);
         cmd.frame_end = (left_ff == 32'd1);
         left_in       = left_ff - 32'd1;
         phase_in      = phase_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= '0;
         phase_ff <= '0;
         left_ff  <= '0;
      end else if (accept) begin
         key_ff   <= key_in;
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/wtfe_cmd_fifo.sv
// Short command queue between the front end and the byte sequencer.
// Depends on wtfe_pkg for the command type and depth.
`default_nettype none
module wtfe_cmd_fifo import wtfe_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic wr_en,
   input  cmd_type   wr_cmd,
   output logic      full,
   output logic      head_valid,
   output cmd_type   head_cmd,
   input  wire logic rd_en
);

   cmd_type              mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CW-1:0]   count_ff, count_in;
   logic                 do_wr, do_rd;

   assign full       = (count_ff == FIFO_CW'(FIFO_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = mem[rd_ptr_ff];
   assign do_wr      = wr_en && !full;
   assign do_rd      = rd_en && head_valid;

   always_comb begin
      count_in = count_ff;
      if (do_wr && !do_rd) count_in = count_ff + 1'b1;
      if (do_rd && !do_wr) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_wr) mem[wr_ptr_ff] <= wr_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_rd) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/wtfe_back.sv
// Back end: emits header bytes, or a data or error word, into the output register.
// Depends on wtfe_pkg; reads the head of wtfe_cmd_fifo.
`default_nettype none
module wtfe_back import wtfe_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  head_valid,
   input  cmd_type    head_cmd,
   output logic       head_pop,
   output logic       empty,
   input  wire logic  pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last,
   output logic       rsp_frame_end,
   output logic       rsp_error
);

   logic       out_valid_ff;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       fend_ff, fend_in;
   logic       err_ff, err_in;
   logic [3:0] idx_ff, idx_in;
   logic       advance;

   assign advance = head_valid && (!out_valid_ff || pop);

   always_comb begin
      byte_in  = head_cmd.data;
      last_in  = 1'b1;
      fend_in  = 1'b0;
      err_in   = 1'b0;
      idx_in   = idx_ff;
      head_pop = 1'b0;
      unique case (head_cmd.kind) inside
         CMD_HDR_SHORT, CMD_HDR_MED, CMD_HDR_LONG: begin
            byte_in = hdr_byte(head_cmd.kind, head_cmd.len, head_cmd.key, idx_ff);
            last_in = (idx_ff == key_pos(head_cmd.kind) + 4'd3);
            if (advance) begin
               head_pop = last_in;
               idx_in   = last_in ? 4'd0 : idx_ff + 4'd1;
            end
         end
         CMD_DATA: begin
            fend_in  = head_cmd.frame_end;
            head_pop = advance;
         end
         default: begin
            byte_in  = 8'h00;
            err_in   = 1'b1;
            head_pop = advance;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         idx_ff <= idx_in;
         if (advance)  out_valid_ff <= 1'b1;
         else if (pop) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
         fend_ff <= fend_in;
         err_ff  <= err_in;
      end
   end

   assign empty         = !out_valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_last      = last_ff;
   assign rsp_frame_end = fend_ff;
   assign rsp_error     = err_ff;

endmodule
`default_nettype wire

FILE: sv/websocket_text_frame_encoder.sv
// Top level of the WebSocket client text frame encoder (masked frames).
// Depends on wtfe_pkg, wtfe_front, wtfe_cmd_fifo and wtfe_back.
//
//   channel   handshake            payload
//   -------   ------------------   -------------------------------------------
//   request   push / full          req_type, req_payload_len, req_mask_key,
//                                  req_data_byte
//   response  empty / pop          rsp_out_byte, rsp_last, rsp_frame_end,
//                                  rsp_error
//
// A payload or error word yields one word; a start word yields 6, 8 or 14 header
// words, one per cycle while pop is held, keeping the sequencer busy until done.
// The output rate is set by the back-end sequencer: one word a cycle at most.
// The four-entry command queue lets new requests enter while headers drain.
// Synchronous reset clears key, phase, length count, queue and output valid flag.
// full rises only when the queue is full; a stalled pop holds the output word.
`default_nettype none
module websocket_text_frame_encoder import wtfe_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic        req_type,
   input  wire logic [31:0] req_payload_len,
   input  wire logic [31:0] req_mask_key,
   input  wire logic [7:0]  req_data_byte,
   output logic             empty,
   input  wire logic        pop,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last,
   output logic             rsp_frame_end,
   output logic             rsp_error
);

   // front end to queue
   logic    cmd_push;
   cmd_type cmd;
   logic    fifo_full;

   // queue to back end
   logic    head_valid;
   cmd_type head_cmd;
   logic    head_pop;

   // classify and mask; state advances on each accepted word except a stray byte
   wtfe_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_type        (req_type),
      .req_payload_len (req_payload_len),
      .req_mask_key    (req_mask_key),
      .req_data_byte   (req_data_byte),
      .fifo_full       (fifo_full),
      .cmd_push        (cmd_push),
      .cmd             (cmd)
   );

   // hold commands so front and back stall independently
   wtfe_cmd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (cmd_push),
      .wr_cmd     (cmd),
      .full       (fifo_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .rd_en      (head_pop)
   );

   // expand headers, register one word for the consumer
   wtfe_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_cmd      (head_cmd),
      .head_pop      (head_pop),
      .empty         (empty),
      .pop           (pop),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last      (rsp_last),
      .rsp_frame_end (rsp_frame_end),
      .rsp_error     (rsp_error)
   );

endmodule
`default_nettype wire

FILE: sv/wtfe_checker.sv
// Port-level checker for the frame encoder, bound to the top level.
// Depends on websocket_text_frame_encoder_assert.svh for the assertion macros.
`default_nettype none
`include "websocket_text_frame_encoder_assert.svh"
module wtfe_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        empty,
   input wire logic        pop,
   input wire logic [7:0]  rsp_out_byte,
   input wire logic        rsp_last,
   input wire logic        rsp_frame_end,
   input wire logic        rsp_error
);

   // an error word is a lone zero word that ends its item
   `WTFE_ASSERT_NOW(a_err_word, !empty && rsp_error, rsp_out_byte == 8'h00 && rsp_last && !rsp_frame_end)

   // the final data word of a frame is a one-word item and never an error
   `WTFE_ASSERT_NOW(a_fend_word, !empty && rsp_frame_end, rsp_last && !rsp_error)

   // nothing waits on the output right after reset
   `WTFE_ASSERT_NOW(a_reset_empty, $past(reset), empty)

   // a word not taken stays put
   `WTFE_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(rsp_out_byte) && $stable(rsp_last))

endmodule

bind websocket_text_frame_encoder wtfe_checker u_checker (.*);
`default_nettype wire

FILE: tb/tb_websocket_text_frame_encoder.sv
// Self-checking testbench for the WebSocket client text frame encoder.
// Depends on wtfe_pkg and websocket_text_frame_encoder; drives request words,
// predicts every wire byte and checks the response stream in order.
`default_nettype none
module tb_websocket_text_frame_encoder import wtfe_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEMS_WANTED = 250;
   localparam int DIR_ROWS     = 25;
   localparam int TAIL_CYCLES  = 40;
   localparam int MAX_REPORTS  = 10;

   // Directed rows either take their expectation from the predictor or carry
   // a hand-written one (single-word results only).
   localparam logic TYPED = 1'b1;
   localparam logic PRED  = 1'b0;

   // One response word as it appears on the rsp_ ports.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       frame_end;
      logic       error;
   } wire_word_type;

   localparam wire_word_type NONE = '0;

   // One request word as it appears on the req_ ports.
   typedef struct packed {
      logic        kind;
      logic [31:0] len;
      logic [31:0] key;
      logic [7:0]  data;
   } stim_type;

   typedef struct packed {
      logic          kind;
      logic [31:0]   len;
      logic [31:0]   key;
      logic [7:0]    data;
      logic          typed;
      wire_word_type want;
   } dir_row_type;

   // Receiver behaviour, redrawn at random whenever its hold counter runs out.
   typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SLOW, RX_BURSTY} rx_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic        req_type = 1'b0;
   logic [31:0] req_payload_len = '0;
   logic [31:0] req_mask_key = '0;
   logic [7:0]  req_data_byte = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last;
   logic        rsp_frame_end;
   logic        rsp_error;

   // Predictor state: key, next key byte index and payload bytes still owed.
   logic [31:0] frame_key = '0;
   logic [1:0]  key_idx = '0;
   logic [31:0] frame_left = '0;

   // Wire bytes predicted but not yet seen on the response side.
   wire_word_type wire_due[$];

   int          mismatches = 0;
   int          items_sent = 0;
   int          starts_sent = 0;
   int          words_checked = 0;
   int          errors_seen = 0;
   int          frame_ends_seen = 0;
   int          burst_left = 0;
   int          rx_hold = 0;
   int          rx_tick = 0;
   rx_mode_type rx_mode = RX_FREE;

   always #5 clock = ~clock;

   websocket_text_frame_encoder dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_type        (req_type),
      .req_payload_len (req_payload_len),
      .req_mask_key    (req_mask_key),
      .req_data_byte   (req_data_byte),
      .empty           (empty),
      .pop             (pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last        (rsp_last),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_error       (rsp_error)
   );

   task automatic due_word(input logic [7:0] b, input logic lst, input logic fend,
                           input logic err);
      wire_word_type w;
      w.out_byte  = b;
      w.last      = lst;
      w.frame_end = fend;
      w.error     = err;
      wire_due.insert(wire_due.size(), w);
   endtask

   // Work out the wire bytes caused by one accepted request word and advance
   // the frame state exactly as the encoder should.
   task automatic encode_request(input stim_type s);
      logic [7:0] hdr [0:13];
      int         n;
      n = 0;
      if (s.kind == REQ_START) begin
         // A start always wins: drop whatever is left of the old frame.
         frame_key  = s.key;
         key_idx    = 2'd0;
         frame_left = s.len;
         hdr[n++] = HDR_FIRST;
         if (s.len <= LEN7_MAX) begin
            hdr[n++] = MASK_FLAG | s.len[7:0];
         end else if (s.len <= LEN16_MAX) begin
            hdr[n++] = MASK_FLAG | {1'b0, LEN16_CODE};
            hdr[n++] = s.len[15:8];
            hdr[n++] = s.len[7:0];
         end else begin
            // 64-bit length form; the upper half is always zero here.
            hdr[n++] = MASK_FLAG | {1'b0, LEN64_CODE};
            for (int i = 0; i < 4; i++) hdr[n++] = 8'h00;
            for (int i = 3; i >= 0; i--) hdr[n++] = s.len[8*i +: 8];
         end
         for (int i = 0; i < 4; i++) hdr[n++] = frame_key[31 - 8*i -: 8];
         for (int i = 0; i < n; i++) due_word(hdr[i], i == n - 1, 1'b0, 1'b0);
      end else if (frame_left == 0) begin
         // Stray payload byte: flag it and leave the state alone.
         due_word(8'h00, 1'b1, 1'b0, 1'b1);
      end else begin
         frame_left = frame_left - 1;
         due_word(s.data ^ frame_key[31 - 8*key_idx -: 8], 1'b1, frame_left == 0, 1'b0);
         key_idx = key_idx + 2'd1;
      end
   endtask

   // Present one request word, hold it until taken, then predict its output.
   // The sender runs in bursts; a new burst may open with a gap.
   task automatic send_word(input stim_type s);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      push            <= 1'b1;
      req_type        <= s.kind;
      req_payload_len <= s.len;
      req_mask_key    <= s.key;
      req_data_byte   <= s.data;
      do @(posedge clock); while (full);
      encode_request(s);
      items_sent++;
      if (s.kind == REQ_START) starts_sent++;
   endtask

   // Hold off the sender until every predicted byte has come out.
   task automatic drain_wire();
      push <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (wire_due.size() != 0);
   endtask

   task automatic check_word();
      wire_word_type got;
      wire_word_type want;
      got = {rsp_out_byte, rsp_last, rsp_frame_end, rsp_error};
      words_checked++;
      if (rsp_error) errors_seen++;
      if (rsp_frame_end) frame_ends_seen++;
      if (wire_due.size() == 0) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected word: byte %02h last %b end %b err %b", $realtime,
                     got.out_byte, got.last, got.frame_end, got.error);
      end else begin
         want = wire_due.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display({"%0t: word %0d: got byte %02h last %b end %b err %b, ",
                         "want byte %02h last %b end %b err %b"},
                        $realtime, words_checked, got.out_byte, got.last, got.frame_end,
                        got.error, want.out_byte, want.last, want.frame_end, want.error);
         end
      end
   endtask

   // Response side: check each word taken, then choose pop for the next edge.
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) check_word();
         if (rx_hold == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            rx_hold = $urandom_range(20, 120);
         end else begin
            rx_hold--;
         end
         rx_tick++;
         case (rx_mode)
            RX_FREE:   pop <= 1'b1;
            RX_COIN:   pop <= 1'($urandom_range(0, 1));
            RX_SLOW:   pop <= ($urandom_range(0, 7) == 0);
            default:   pop <= (rx_tick % 8) < 5;
         endcase
      end
   end

   // Directed rows: reset behaviour, the three header forms and their
   // boundaries, empty frames, abandoned frames and stray payload bytes.
   //   kind         len            key            data   typed  expected word
   function automatic dir_row_type directed_row(input int n);
      dir_row_type r;
      case (n)
         // stray byte straight after reset
         0:  r = {REQ_PAYLOAD, 32'd0,          32'd0,          8'hA5, TYPED, 8'h00, 1'b1, 1'b0, 1'b1};
         // empty frame, all-ones key, then a byte that has no home
         1:  r = {REQ_START,   32'd0,          32'hFFFF_FFFF,  8'h00, PRED,  NONE};
         2:  r = {REQ_PAYLOAD, 32'd0,          32'd0,          8'hFF, TYPED, 8'h00, 1'b1, 1'b0, 1'b1};
         // one-byte frame with a zero key passes the byte through
         3:  r = {REQ_START,   32'd1,          32'd0,          8'h00, PRED,  NONE};
         4:  r = {REQ_PAYLOAD, 32'd0,          32'd0,          8'hFF, TYPED, 8'hFF, 1'b1, 1'b1, 1'b0};
         5:  r = {REQ_PAYLOAD, 32'd0,          32'd0,          8'h00, TYPED, 8'h00, 1'b1, 1'b0, 1'b1};
         // top of the 7-bit form, abandoned part way
         6:  r = {REQ_START,   32'd125,        32'hA5A5_5A5A,  8'h00, PRED,  NONE};
         7:  r = {REQ_PAYLOAD, 32'd0,          32'd0,          8'h00, PRED,  NONE};
         8:  r = {REQ_PAYLOAD, 32'd0,          32'd0,          8'hFF, PRED,  NONE};
         // bottom and top of the 16-bit form
         9:  r = {REQ_START,   32'd126,        32'h0123_4567,  8'h00, PRED,  NONE};
         10: r = {REQ_PAYLOAD, 32'd0,          32'd0,          8'h3C, PRED,  NONE};
         11: r = {REQ_START,   32'h0000_FFFF,  32'h89AB_CDEF,  8'h00, PRED,  NONE};
         12: r = {REQ_PAYLOAD, 32'd0,          32'd0,          8'hAA, PRED,  NONE};
         // bottom and top of the 64-bit form
         13: r = {REQ_START,   32'h0001_0000,  32'hDEAD_BEEF,  8'h00, PRED,  NONE};
         14: r = {REQ_PAYLOAD, 32'd0,          32'd0,          8'h55, PRED,  NONE};
         15: r = {REQ_START,   32'hFFFF_FFFF,  32'hFFFF_FFFF,  8'h00, PRED,  NONE};
         16: r = {REQ_PAYLOAD, 32'd0,          32'd0,          8'hFF, PRED,  NONE};
         // short frame run to its end, then one byte too many
         17: r = {REQ_START,   32'd3,          32'h1122_3344,  8'h00, PRED,  NONE};
         18: r = {REQ_PAYLOAD, 32'd0,          32'd0,          8'h01, PRED,  NONE};
         19: r = {REQ_PAYLOAD, 32'd0,          32'd0,          8'h02, PRED,  NONE};
         20: r = {REQ_PAYLOAD, 32'd0,          32'd0,          8'h03, PRED,  NONE};
         21: r = {REQ_PAYLOAD, 32'd0,          32'd0,          8'h04, TYPED, 8'h00, 1'b1, 1'b0, 1'b1};
         // zero key again: bytes come out unchanged, the second ends the frame
         22: r = {REQ_START,   32'd2,          32'd0,          8'h00, PRED,  NONE};
         23: r = {REQ_PAYLOAD, 32'd0,          32'd0,          8'h80, TYPED, 8'h80, 1'b1, 1'b0, 1'b0};
         default:
             r = {REQ_PAYLOAD, 32'd0,          32'd0,          8'h7F, TYPED, 8'h7F, 1'b1, 1'b1, 1'b0};
      endcase
      return r;
   endfunction

   initial begin
      dir_row_type row;
      stim_type    s;
      int          pick;
      int          n_bytes;
      logic [31:0] frame_len;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part: walk the table; typed rows swap the predicted word for
      // the hand-written one so the predictor itself gets checked there.
      for (int n = 0; n < DIR_ROWS; n++) begin
         row = directed_row(n);
         send_word({row.kind, row.len, row.key, row.data});
         if (row.typed) wire_due[wire_due.size() - 1] = row.want;
      end
      drain_wire();

      // Random part: mostly well-formed frames with random content, a few
      // truncated or overrun frames, and some raw noise words.
      while (items_sent < ITEMS_WANTED) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            s = {1'($urandom_range(0, 1)), $urandom, $urandom, 8'($urandom)};
            send_word(s);
         end else begin
            if ($urandom_range(0, 9) == 0) drain_wire();
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               frame_len = $urandom_range(0, 8);
               n_bytes   = frame_len;
               if ($urandom_range(0, 7) == 0) n_bytes = $urandom_range(0, frame_len);
            end else if (pick < 75) begin
               frame_len = $urandom_range(120, 131);
               n_bytes   = $urandom_range(0, 5);
            end else if (pick < 87) begin
               frame_len = $urandom_range(65530, 65541);
               n_bytes   = $urandom_range(0, 4);
            end else begin
               frame_len = $urandom;
               n_bytes   = $urandom_range(0, 4);
            end
            // Now and then overrun the frame to provoke stray-byte errors.
            if ($urandom_range(0, 7) == 0) n_bytes += $urandom_range(1, 2);
            send_word({REQ_START, frame_len, $urandom, 8'($urandom)});
            for (int k = 0; k < n_bytes; k++)
               send_word({REQ_PAYLOAD, $urandom, $urandom, 8'($urandom)});
         end
      end

      // Let the encoder empty out, then watch a while for stray words.
      drain_wire();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d request words (%0d frame starts); checked %0d response words,",
               items_sent, starts_sent, words_checked);
      $display("  %0d frame ends and %0d stray-byte errors among them, %0d mismatches.",
               frame_ends_seen, errors_seen, mismatches);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
`default_nettype wire

FILE: websocket_text_frame_encoder.f
+incdir+sv
sv/wtfe_pkg.sv
sv/wtfe_front.sv
sv/wtfe_cmd_fifo.sv
sv/wtfe_back.sv
sv/websocket_text_frame_encoder.sv
sv/wtfe_checker.sv
tb/tb_websocket_text_frame_encoder.sv
